>>> hw/rtl/txcon_pkg.sv
// Shared types and constants for the text console character engine.
// Used by txcon_ctrl, txcon_screen_ram, text_console_char_engine and the testbench; depends on nothing.
`default_nettype none

package txcon_pkg;

   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 25;
   localparam int CELL_W   = 16;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
   localparam logic [7:0]        ATTR_BYTE  = 8'h0F;

   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_FF    = 8'd12;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] PRINT_LO = 8'd32;
   localparam logic [7:0] PRINT_HI = 8'd126;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_CLEAR,
      ST_SCROLL,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/txcon_screen_ram.sv
// Screen cell store: one write port and one read port with registered read data.
// Standalone memory; depends on txcon_pkg for the cell width.
`default_nettype none

module txcon_screen_ram
   import txcon_pkg::*;
#(
   parameter int DEPTH  = DEF_ROWS * DEF_COLS,
   parameter int ADDR_W = $clog2(DEF_ROWS * DEF_COLS)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [CELL_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] screen_mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= screen_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/txcon_ctrl.sv
// Sequencer for the console: cursor state, character decode, clear and scroll
// sweeps, and the result register. Depends on txcon_pkg; drives txcon_screen_ram.
`default_nettype none

module txcon_ctrl
   import txcon_pkg::*;
#(
   parameter int COLS   = DEF_COLS,
   parameter int ROWS   = DEF_ROWS,
   parameter int ADDR_W = $clog2(DEF_ROWS * DEF_COLS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_kind,
   input  wire logic [7:0]        req_char_code,
   input  wire logic [4:0]        req_read_row,
   input  wire logic [6:0]        req_read_col,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [4:0]        rsp_cursor_row,
   output logic      [6:0]        rsp_cursor_col,
   output logic      [10:0]       rsp_cursor_pos,
   output logic      [15:0]       rsp_cell_word,
   output logic                   rsp_scrolled,
   output logic                   mem_wr_en,
   output logic      [ADDR_W-1:0] mem_wr_addr,
   output logic      [CELL_W-1:0] mem_wr_data,
   output logic                   mem_rd_en,
   output logic      [ADDR_W-1:0] mem_rd_addr,
   input  wire logic [CELL_W-1:0] mem_rd_data
);

   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W = $clog2(COLS);
   localparam int CELLS = ROWS * COLS;
   localparam int MOVE  = (ROWS - 1) * COLS;

   localparam logic [ADDR_W-1:0] LAST_PTR = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] MOVE_PTR = ADDR_W'(MOVE);
   localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLS);
   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLS - 1);

   state_type state_ff, state_in;

   logic              kind_ff, kind_in;
   logic [7:0]        code_ff, code_in;
   logic [4:0]        rr_ff, rr_in;
   logic [6:0]        rc_ff, rc_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              scrolled_ff, scrolled_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [ADDR_W-1:0] pipe_addr_ff, pipe_addr_in;
   logic              pipe_blank_ff, pipe_blank_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [4:0]        rsp_row_ff, rsp_row_in;
   logic [6:0]        rsp_col_ff, rsp_col_in;
   logic [10:0]       rsp_pos_ff, rsp_pos_in;
   logic [15:0]       rsp_cell_ff, rsp_cell_in;
   logic              rsp_scr_ff, rsp_scr_in;

   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] read_addr;
   logic              read_in_range;
   logic [COL_W:0]    tab_col;
   logic              tab_wrap;
   logic [31:0]       row_wide;
   logic [31:0]       col_wide;
   logic [31:0]       pos_wide;
   logic              slot_free;

   assign row_wide      = 32'(row_ff);
   assign col_wide      = 32'(col_ff);
   assign pos_wide      = row_wide * COLS + col_wide;
   assign cur_addr      = pos_wide[ADDR_W-1:0];
   assign read_in_range = (32'(rr_ff) < ROWS) && (32'(rc_ff) < COLS);
   assign read_addr     = ADDR_W'(32'(rr_ff) * COLS + 32'(rc_ff));
   assign tab_col       = ({1'b0, col_ff} + (COL_W + 1)'(8)) & ~((COL_W + 1)'(7));
   assign tab_wrap      = 32'(tab_col) >= COLS;
   assign slot_free     = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      code_ff       <= code_in;
      rr_ff         <= rr_in;
      rc_ff         <= rc_in;
      cell_ff       <= cell_in;
      scrolled_ff   <= scrolled_in;
      ptr_ff        <= ptr_in;
      pipe_addr_ff  <= pipe_addr_in;
      pipe_blank_ff <= pipe_blank_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_scr_ff    <= rsp_scr_in;
   end

   always_comb begin
      logic newline;
      newline       = 1'b0;
      state_in      = state_ff;
      kind_in       = kind_ff;
      code_in       = code_ff;
      rr_in         = rr_ff;
      rc_in         = rc_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cell_in       = cell_ff;
      scrolled_in   = scrolled_ff;
      ptr_in        = ptr_ff;
      pipe_vld_in   = 1'b0;
      pipe_addr_in  = pipe_addr_ff;
      pipe_blank_in = pipe_blank_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_scr_in    = rsp_scr_ff;
      req_ready     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = read_addr;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = cur_addr;
      mem_wr_data   = BLANK_CELL;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = req_kind;
               code_in  = req_char_code;
               rr_in    = req_read_row;
               rc_in    = req_read_col;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cell_in     = '0;
            scrolled_in = 1'b0;
            state_in    = ST_FINISH;
            if (kind_ff == KIND_READ) begin
               if (read_in_range) begin
                  mem_rd_en = 1'b1;
                  state_in  = ST_READ;
               end
            end else begin
               case (code_ff)
                  CH_BS: begin
                     mem_wr_en = 1'b1;
                     if (col_ff != '0) begin
                        col_in = col_ff - COL_W'(1);
                     end else if (row_ff != '0) begin
                        row_in = row_ff - ROW_W'(1);
                        col_in = COL_LAST;
                     end
                  end
                  CH_TAB: begin
                     if (tab_wrap) begin
                        col_in  = '0;
                        newline = 1'b1;
                     end else begin
                        col_in = tab_col[COL_W-1:0];
                     end
                  end
                  CH_LF: begin
                     col_in  = '0;
                     newline = 1'b1;
                  end
                  CH_FF: begin
                     row_in   = '0;
                     col_in   = '0;
                     ptr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CH_CR: begin
                     col_in = '0;
                  end
                  default: begin
                     if (code_ff inside {[PRINT_LO:PRINT_HI]}) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = {ATTR_BYTE, code_ff};
                        if (col_ff == COL_LAST) begin
                           col_in  = '0;
                           newline = 1'b1;
                        end else begin
                           col_in = col_ff + COL_W'(1);
                        end
                     end
                  end
               endcase
               if (newline) begin
                  if (row_ff == ROW_LAST) begin
                     scrolled_in = 1'b1;
                     ptr_in      = '0;
                     state_in    = ST_SCROLL;
                  end else begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end
            end
         end
         ST_READ: begin
            cell_in  = mem_rd_data;
            state_in = ST_FINISH;
         end
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff;
            if (ptr_ff == LAST_PTR) begin
               state_in = ST_FINISH;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_SCROLL: begin
            if (ptr_ff < MOVE_PTR) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff + COLS_A;
            end
            pipe_vld_in   = 1'b1;
            pipe_addr_in  = ptr_ff;
            pipe_blank_in = ptr_ff >= MOVE_PTR;
            if (ptr_ff == LAST_PTR) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_wide[4:0];
               rsp_col_in   = col_wide[6:0];
               rsp_pos_in   = pos_wide[10:0];
               rsp_cell_in  = cell_ff;
               rsp_scr_in   = scrolled_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pipe_vld_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = pipe_addr_ff;
         mem_wr_data = pipe_blank_ff ? BLANK_CELL : mem_rd_data;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_word  = rsp_cell_ff;
   assign rsp_scrolled   = rsp_scr_ff;

endmodule

`default_nettype wire

>>> hw/rtl/text_console_char_engine.sv
// Top level of the text console character engine.
// Depends on txcon_pkg, txcon_screen_ram and txcon_ctrl.
//
// The engine keeps a ROWS x COLS text screen in a single on-chip memory and a
// cursor. A character transfer edits the screen and/or moves the cursor
// (backspace, tab, line feed, form feed, carriage return, printable codes) or
// is ignored; a read transfer returns one cell, or zero outside the screen.
// Every transfer yields exactly one result carrying the cursor after any
// scroll. Items are handled one at a time by a sequencer in front of the
// memory. A plain character passes through the execute and finish states,
// the latter registering its result. A read adds a state that captures the
// memory's registered read data. Form feed writes every cell once in a
// clear sweep. A scroll moves one cell per cycle through the memory's read
// and write ports, then drains the last pipelined write before finishing.
// The result register lets a new item be accepted while the previous result
// waits; that item then stalls in its last cycle until the result is taken.
// Cells are undefined after reset until a form feed clears the screen.
`default_nettype none

module text_console_char_engine
   import txcon_pkg::*;
#(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [4:0]  req_read_row,
   input  wire logic [6:0]  req_read_col,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [4:0]  rsp_cursor_row,
   output logic      [6:0]  rsp_cursor_col,
   output logic      [10:0] rsp_cursor_pos,
   output logic      [15:0] rsp_cell_word,
   output logic             rsp_scrolled
);

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;

   txcon_ctrl #(
      .COLS   (COLS),
      .ROWS   (ROWS),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_word  (rsp_cell_word),
      .rsp_scrolled   (rsp_scrolled),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   txcon_screen_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The screen is never written while a new transfer is taken.
   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && mem_wr_en))
      else $error("screen write during request transfer");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item is in flight");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_cursor_row == 5'(ROWS - 1)))
      else $error("scrolled result not on the last row");

   a_wr_addr_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (32'(mem_wr_addr) < CELLS))
      else $error("screen write outside the screen");

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_char_engine at its default 80 x 25 screen.
// Depends on txcon_pkg and the engine RTL. Text runs, control codes and cell reads
// are checked against a shadow screen and cursor that this file keeps.

module testbench;
   import txcon_pkg::*;

   localparam int COLS          = DEF_COLS;
   localparam int ROWS          = DEF_ROWS;
   localparam int CELLS         = COLS * ROWS;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SCROLL_BUDGET = 150;
   localparam int CLEAR_BUDGET  = 25;
   localparam int LONG_HOLD     = 400;
   localparam int PRINT_CAP     = 40;

   typedef struct packed {
      logic       kind;
      logic [7:0] code;
      logic [4:0] row;
      logic [6:0] col;
   } console_op_type;

   typedef struct packed {
      logic [4:0]  row;
      logic [6:0]  col;
      logic [10:0] pos;
      logic [15:0] cell_word;
      logic        scrolled;
   } console_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_CHAR;
   logic [7:0]  req_char_code = '0;
   logic [4:0]  req_read_row = '0;
   logic [6:0]  req_read_col = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_col;
   logic [10:0] rsp_cursor_pos;
   logic [15:0] rsp_cell_word;
   logic        rsp_scrolled;

   console_op_type   keystroke_q[$];
   console_view_type screen_view_q[$];
   console_op_type   on_offer;
   console_view_type due;

   logic [15:0] shadow_cells [CELLS];
   bit          cell_set [CELLS];
   int          cur_row = 0;
   int          cur_col = 0;

   bit offering = 0;
   bit offer_taken = 0;
   bit long_hold_req = 0;
   int send_gap = 0;
   int hold_left = 0;
   int ready_gap = 0;
   int calm_left = 0;
   int cycle_count = 0;
   int issued_count = 0;
   int accepted_count = 0;
   int useful_count = 0;
   int read_count = 0;
   int scroll_count = 0;
   int clear_count = 0;
   int checked_count = 0;
   int error_count = 0;

   text_console_char_engine dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_word  (rsp_cell_word),
      .rsp_scrolled   (rsp_scrolled)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void mark_cell(int idx, logic [15:0] value);
      shadow_cells[idx] = value;
      cell_set[idx] = 1;
   endfunction

   function automatic console_view_type step_console(console_op_type op);
      console_view_type view;
      logic [15:0]      word;
      bit               did_scroll;
      int               k;
      word = '0;
      did_scroll = 0;
      if (op.kind == KIND_CHAR) begin
         case (op.code)
            CH_BS: begin
               mark_cell(cur_row * COLS + cur_col, BLANK_CELL);
               if (cur_col > 0) begin
                  cur_col--;
               end else if (cur_row > 0) begin
                  cur_row--;
                  cur_col = COLS - 1;
               end
            end
            CH_TAB: begin
               cur_col = (cur_col + 8) & ~7;
               if (cur_col >= COLS) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            CH_LF: begin
               cur_col = 0;
               cur_row++;
            end
            CH_FF: begin
               for (k = 0; k < CELLS; k++) mark_cell(k, BLANK_CELL);
               cur_row = 0;
               cur_col = 0;
               clear_count++;
            end
            CH_CR: begin
               cur_col = 0;
            end
            default: begin
               if (op.code >= PRINT_LO && op.code <= PRINT_HI) begin
                  mark_cell(cur_row * COLS + cur_col, {ATTR_BYTE, op.code});
                  cur_col++;
                  if (cur_col >= COLS) begin
                     cur_col = 0;
                     cur_row++;
                  end
               end
            end
         endcase
         if (cur_row >= ROWS) begin
            for (k = 0; k < CELLS - COLS; k++) begin
               shadow_cells[k] = shadow_cells[k + COLS];
               cell_set[k] = cell_set[k + COLS];
            end
            for (k = CELLS - COLS; k < CELLS; k++) mark_cell(k, BLANK_CELL);
            cur_row = ROWS - 1;
            did_scroll = 1;
            scroll_count++;
         end
      end else if (op.row < ROWS && op.col < COLS) begin
         word = shadow_cells[op.row * COLS + op.col];
      end
      view.row = cur_row[4:0];
      view.col = cur_col[6:0];
      view.pos = 11'(cur_row * COLS + cur_col);
      view.cell_word = word;
      view.scrolled = did_scroll;
      return view;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 8);
      return $urandom_range(20, 80);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("cycle %0d: %s is 0x%0h, expected 0x%0h", cycle_count, what, got, want);
   endtask

   task automatic queue_char(int code);
      console_op_type op;
      op.kind = KIND_CHAR;
      op.code = 8'(code);
      op.row = 5'($urandom_range(0, 31));
      op.col = 7'($urandom_range(0, 127));
      keystroke_q.push_back(op);
      issued_count++;
      if (code == CH_BS || code == CH_TAB || code == CH_LF || code == CH_FF ||
          code == CH_CR || (code >= PRINT_LO && code <= PRINT_HI))
         useful_count++;
   endtask

   task automatic queue_read(int row, int col);
      console_op_type op;
      op.kind = KIND_READ;
      op.code = 8'($urandom_range(0, 255));
      op.row = 5'(row);
      op.col = 7'(col);
      keystroke_q.push_back(op);
      issued_count++;
      useful_count++;
      read_count++;
   endtask

   task automatic queue_read_off_screen();
      if ($urandom_range(0, 1))
         queue_read($urandom_range(ROWS, 31), $urandom_range(0, 127));
      else
         queue_read($urandom_range(0, 31), $urandom_range(COLS, 127));
   endtask

   // Reads only cells that hold a defined value; otherwise reads off the screen.
   task automatic queue_read_known();
      int row;
      int col;
      int tries;
      bit found;
      found = 0;
      for (tries = 0; tries < 40 && !found; tries++) begin
         row = ($urandom_range(0, 2) == 0) ? cur_row : $urandom_range(0, ROWS - 1);
         col = $urandom_range(0, COLS - 1);
         found = cell_set[row * COLS + col];
      end
      if (found) queue_read(row, col);
      else queue_read_off_screen();
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 499) == 0) calm_left = $urandom_range(100, 400);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("no progress after %0d cycles", cycle_count);
         $display("testbench failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         screen_view_q.push_back(step_console({req_kind, req_char_code, req_read_row,
                                               req_read_col}));
         accepted_count++;
         offer_taken = 1;
      end
   end

   always @(negedge clock) begin
      if (offer_taken) begin
         offer_taken = 0;
         offering = 0;
         if (calm_left == 0 && $urandom_range(0, 99) < 45) send_gap = pick_gap();
      end
      if (!offering && !reset) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (keystroke_q.size() > 0) begin
            on_offer = keystroke_q.pop_front();
            offering = 1;
         end
      end
      req_valid <= offering;
      if (offering) begin
         req_kind <= on_offer.kind;
         req_char_code <= on_offer.code;
         req_read_row <= on_offer.row;
         req_read_col <= on_offer.col;
      end
   end

   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) hold_left--;
      else if (ready_gap > 0) ready_gap--;
      else if (calm_left == 0 && $urandom_range(0, 99) < 20) ready_gap = pick_gap();
      rsp_ready <= !reset && hold_left == 0 && ready_gap == 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (screen_view_q.size() == 0) begin
            report_mismatch("cursor_pos of a result with no transfer pending",
                            rsp_cursor_pos, 0);
         end else begin
            due = screen_view_q.pop_front();
            if (rsp_cursor_row !== due.row)
               report_mismatch("cursor_row", rsp_cursor_row, due.row);
            if (rsp_cursor_col !== due.col)
               report_mismatch("cursor_col", rsp_cursor_col, due.col);
            if (rsp_cursor_pos !== due.pos)
               report_mismatch("cursor_pos", rsp_cursor_pos, due.pos);
            if (rsp_cell_word !== due.cell_word)
               report_mismatch("cell_word", rsp_cell_word, due.cell_word);
            if (rsp_scrolled !== due.scrolled)
               report_mismatch("scrolled", rsp_scrolled, due.scrolled);
            checked_count++;
         end
      end
   end

   initial begin
      int seg;
      int pick;
      int n;
      int k;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_read(31, 127);
      queue_read(ROWS, 0);
      queue_read(0, COLS);
      queue_char("A");
      queue_read(0, 0);
      queue_char(PRINT_LO);
      queue_char(PRINT_HI);
      queue_char(8'd127);
      queue_char(8'd0);
      queue_char(8'd255);
      queue_char(8'd31);
      queue_char(CH_BS);
      queue_read(0, 2);
      queue_read(0, 3);
      queue_char(CH_CR);
      queue_char(CH_BS);
      queue_char(CH_FF);
      queue_read(ROWS - 1, COLS - 1);
      queue_char(CH_TAB);
      queue_char(CH_LF);
      queue_char(CH_BS);
      queue_char(CH_TAB);
      queue_char(CH_BS);
      queue_char("Z");
      queue_read(1, 0);

      // Run down to the last row, then scroll by line feed, by tab and by line wrap.
      wait (accepted_count == issued_count);
      n = ROWS - cur_row;
      for (k = 0; k < n; k++) queue_char(CH_LF);
      for (k = 0; k < COLS / 8; k++) queue_char(CH_TAB);
      for (k = 0; k < COLS; k++) queue_char($urandom_range(PRINT_LO, PRINT_HI));
      for (k = 0; k < 4; k++) queue_read($urandom_range(ROWS - 3, ROWS - 1),
                                         $urandom_range(0, COLS - 1));

      useful_count = 0;
      seg = 0;
      while (useful_count < RANDOM_ITEMS) begin
         wait (accepted_count == issued_count);
         seg++;
         pick = $urandom_range(0, 99);
         if (seg % 50 == 4) begin
            long_hold_req = 1;
            pick = 0;
         end
         if (pick < 50) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(1, 40);
            for (k = 0; k < n; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 6) queue_char(CH_TAB);
               else if (pick < 10) queue_char(CH_BS);
               else if (pick < 12) queue_char(CH_CR);
               else if (pick < 14) queue_char($urandom_range(0, 31));
               else queue_char($urandom_range(PRINT_LO, PRINT_HI));
            end
            if (scroll_count < SCROLL_BUDGET && $urandom_range(0, 1)) queue_char(CH_LF);
         end else if (pick < 68) begin
            n = $urandom_range(2, 10);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 6) == 0) queue_read_off_screen();
               else queue_read_known();
            end
         end else if (pick < 78) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) queue_char($urandom_range(0, 255));
         end else if (pick < 88) begin
            if (scroll_count < SCROLL_BUDGET) begin
               n = $urandom_range(1, 30);
               for (k = 0; k < n; k++) queue_char(CH_LF);
            end
         end else if (pick < 96) begin
            n = $urandom_range(1, 100);
            for (k = 0; k < n; k++) queue_char(CH_BS);
         end else if (pick < 98) begin
            if (clear_count < CLEAR_BUDGET) queue_char(CH_FF);
         end else begin
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) queue_char(CH_TAB);
         end
      end

      wait (accepted_count == issued_count);
      wait (screen_view_q.size() == 0);
      repeat (20) @(posedge clock);
      $display("ran %0d transfers: %0d cell reads, %0d scrolls, %0d screen clears",
               issued_count, read_count, scroll_count, clear_count);
      $display("checked %0d results, found %0d mismatches", checked_count, error_count);
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/txcon_pkg.sv
hw/rtl/txcon_screen_ram.sv
hw/rtl/txcon_ctrl.sv
hw/rtl/text_console_char_engine.sv
verif/testbench.sv
